[design/inversion_counter_core_defines.svh]
// Assertion macros shared by the inversion counter RTL.
// Needs nothing else; define ASSERT_OFF to compile the checks out.
`ifndef INVERSION_COUNTER_CORE_DEFINES_SVH
`define INVERSION_COUNTER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

[design/icc_pkg.sv]
// Types and constants of the inversion counter.
// Used by icc_cell and inversion_counter_core; depends on nothing.
package icc_pkg;

    localparam int MAX_ITEMS = 256;
    localparam int COUNT_W   = 15;
    localparam int PART_W    = $clog2(MAX_ITEMS);
    localparam int FILL_W    = $clog2(MAX_ITEMS + 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic signed [63:0] value;
        logic               is_last;
    } in_word_t;

    typedef struct packed {
        logic [COUNT_W-1:0] inversion_count;
        logic               overflowed;
    } out_word_t;

    typedef struct packed {
        logic               valid;
        logic               placed;
        logic               last;
        logic signed [63:0] value;
        logic [PART_W-1:0]  cnt;
    } token_t;

endpackage

[design/icc_cell.sv]
// One slot of the inversion counter chain: holds one stored value.
// Depends on icc_pkg and inversion_counter_core_defines.svh.
`include "inversion_counter_core_defines.svh"

module icc_cell
    import icc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   clear,
    input  token_t tok_in,
    output token_t tok_out
);

    logic               slot_valid_reg;
    logic               slot_valid_next;
    logic signed [63:0] slot_value_reg;
    logic signed [63:0] slot_value_next;
    logic               tok_valid_reg;
    token_t             tok_reg;
    token_t             tok_next;

    always_comb
    begin
        tok_next        = tok_in;
        slot_valid_next = slot_valid_reg;
        slot_value_next = slot_value_reg;
        if (tok_in.valid && !tok_in.placed)
        begin
            if (!slot_valid_reg)
            begin
                tok_next.placed = 1'b1;
                slot_valid_next = 1'b1;
                slot_value_next = tok_in.value;
            end
            else if (slot_value_reg > tok_in.value)
            begin
                tok_next.cnt = tok_in.cnt + PART_W'(1);
            end
        end
        if (clear)
        begin
            slot_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
            tok_valid_reg  <= 1'b0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            tok_valid_reg  <= tok_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_value_reg <= slot_value_next;
        tok_reg        <= tok_next;
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = tok_valid_reg;
    end

    `ASSERT_PROP(a_slot_holds, clk, rst_n, (slot_valid_reg && !clear) |=> slot_valid_reg, "slot lost its value without a clear")
    `ASSERT_PROP(a_value_stable, clk, rst_n, (slot_valid_reg && !clear) |=> $stable(slot_value_reg), "stored value changed")
    `ASSERT_PROP(a_empty_places, clk, rst_n, (tok_in.valid && !slot_valid_reg) |=> (tok_out.valid && tok_out.placed), "word passed an empty slot unplaced")

endmodule

[design/inversion_counter_core.sv]
// Top level of the inversion counter: input control, cell chain, result total.
// Depends on icc_pkg, icc_cell and inversion_counter_core_defines.svh.
//
//  channel  | ports                      | handshake
//  ---------+----------------------------+-------------------------------
//  input    | start, busy, item          | taken when start && !busy
//  result   | result_valid, result       | one-cycle strobe, no back-pressure
//
// A word that is not last is taken every cycle while busy is low. Each word
// runs through the chain of MAX_ITEMS cells, one cell per cycle, and is summed
// at the tail. After a last word busy stays high until the result strobe; the
// chain and counters clear on that same edge. Reset clears all control state
// at once; the receiver cannot stall.
`include "inversion_counter_core_defines.svh"

module inversion_counter_core
    import icc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_word_t  item,
    output logic      result_valid,
    output out_word_t result
);

    token_t             tok [0:MAX_ITEMS];
    logic               accept;
    logic               full;
    logic               clear;
    logic [COUNT_W:0]   sum_ext;
    logic [COUNT_W-1:0] sum_sat;

    logic               busy_reg;
    logic               busy_next;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic [COUNT_W-1:0] sum_reg;
    logic [COUNT_W-1:0] sum_next;
    logic               result_valid_reg;
    logic               result_valid_next;
    out_word_t          result_reg;
    out_word_t          result_next;

    assign accept = start && !busy_reg;
    assign full   = (fill_reg == FILL_W'(MAX_ITEMS));

    // A word that arrives at full capacity enters only if it closes the
    // sequence, already placed so that it adds nothing on its way.
    always_comb
    begin
        tok[0].valid  = accept && (!full || item.is_last);
        tok[0].placed = full;
        tok[0].last   = item.is_last;
        tok[0].value  = item.value;
        tok[0].cnt    = '0;
    end

    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_chain
        icc_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .clear   (clear),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    assign clear   = tok[MAX_ITEMS].valid && tok[MAX_ITEMS].last;
    assign sum_ext = {1'b0, sum_reg} + (COUNT_W+1)'(tok[MAX_ITEMS].cnt);
    assign sum_sat = (sum_ext > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum_ext[COUNT_W-1:0];

    always_comb
    begin
        busy_next         = busy_reg;
        fill_next         = fill_reg;
        ovf_next          = ovf_reg;
        sum_next          = sum_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        if (accept)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
            if (item.is_last)
            begin
                busy_next = 1'b1;
            end
        end
        if (tok[MAX_ITEMS].valid)
        begin
            sum_next = sum_sat;
        end
        if (clear)
        begin
            result_valid_next           = 1'b1;
            result_next.inversion_count = sum_sat;
            result_next.overflowed      = ovf_reg;
            busy_next                   = 1'b0;
            fill_next                   = '0;
            ovf_next                    = 1'b0;
            sum_next                    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            fill_reg         <= '0;
            ovf_reg          <= 1'b0;
            sum_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg         <= busy_next;
            fill_reg         <= fill_next;
            ovf_reg          <= ovf_next;
            sum_reg          <= sum_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy         = busy_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ASSERT_PROP(a_emit_after_busy, clk, rst_n, result_valid_reg |-> $past(busy_reg), "result word without a pending last word")
    `ASSERT_NEVER(a_fill_range, clk, rst_n, fill_reg > FILL_W'(MAX_ITEMS), "fill count beyond capacity")
    `ASSERT_NEVER(a_last_needs_busy, clk, rst_n, clear && !busy_reg, "last word reached the tail while idle")

endmodule
